// ===== rtl/core/pgr_pkg.sv =====
// Shared constants for the paragraph greedy rewrap block.
package pgr_pkg;

	// Whitespace byte codes
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_NEWLINE = 8'd10;

	// Field widths fixed by the interface
	localparam int BYTE_BITS    = 8;
	localparam int WIDTH_BITS   = 8;
	localparam int OUT_POS_BITS = 16;

	// Default sizes of the running counters
	localparam int POSITION_BITS_DEF = 16;
	localparam int COLUMN_BITS_DEF   = 12;

endpackage

// ===== rtl/core/paragraph_greedy_rewrap.sv =====
// Greedy paragraph rewrap: one byte a cycle, a whitespace decision at each word end.
// A byte goes through the input register, then its decision, if any, into the output register.
// Throughput: one byte per cycle; the input register stalls only when a result is due
// and the output register still holds one that has not been taken.
// Reset (arst_n low): line_width clears to 0, all paragraph state and valids clear.
// The column update is two saturating adds and a compare in the stage after the input register.
module paragraph_greedy_rewrap
	import pgr_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF,
	parameter int COLUMN_BITS   = COLUMN_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_wr_en,
	input  logic [WIDTH_BITS-1:0]   cfg_wr_data,
	// byte input
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [BYTE_BITS-1:0]    text_byte,
	input  logic                    para_last,
	// decision output
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [OUT_POS_BITS-1:0] ws_position,
	output logic                    becomes_newline,
	output logic                    was_changed
);

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
	localparam logic [COLUMN_BITS-1:0]   COL_MAX = '1;
	localparam int WIDE_POS = (POSITION_BITS > OUT_POS_BITS) ? POSITION_BITS : OUT_POS_BITS;

	// saturating column add
	function automatic logic [COLUMN_BITS-1:0] col_add(input logic [COLUMN_BITS-1:0] a,
			input logic [COLUMN_BITS-1:0] b);
		logic [COLUMN_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COLUMN_BITS] ? COL_MAX : s[COLUMN_BITS-1:0];
	endfunction

	// configuration register
	logic [WIDTH_BITS-1:0] line_width_q;

	// input register
	logic                 valid_s1;
	logic [BYTE_BITS-1:0] byte_s1;
	logic                 last_s1;

	// paragraph state
	logic [COLUMN_BITS-1:0]   column_q;
	logic [POSITION_BITS-1:0] byte_pos_q;
	logic                     inside_word_q;
	logic                     prev_nl_q;
	logic                     pend_valid_q;
	logic [POSITION_BITS-1:0] pend_pos_q;
	logic                     pend_nl_q;
	logic [COLUMN_BITS-1:0]   word_len_q;

	// output register
	logic                    out_valid_q;
	logic [OUT_POS_BITS-1:0] ws_position_q;
	logic                    becomes_nl_q;
	logic                    was_changed_q;

	// combinational step
	logic                     is_ws;
	logic                     word_start;
	logic [COLUMN_BITS-1:0]   wl_inc;
	logic                     dec_pv;
	logic [POSITION_BITS-1:0] dec_pos;
	logic                     dec_pnl;
	logic [COLUMN_BITS-1:0]   dec_wl;
	logic [COLUMN_BITS-1:0]   end_col;
	logic                     nl;
	logic                     do_decide;
	logic [COLUMN_BITS-1:0]   col_ws;
	logic [POSITION_BITS-1:0] start_pos;
	logic                     out_free;
	logic                     fire;
	logic [WIDE_POS-1:0]      pos_wide;

	always_comb begin
		is_ws      = (byte_s1 == CH_SPACE) || (byte_s1 == CH_NEWLINE);
		word_start = !is_ws && !inside_word_q;

		// whitespace offset ahead of a new word
		if (byte_pos_q == '0) begin
			start_pos = '0;
		end else if (byte_pos_q == POS_MAX) begin
			start_pos = POS_MAX;
		end else begin
			start_pos = byte_pos_q - POSITION_BITS'(1);
		end

		wl_inc = col_add(word_start ? '0 : word_len_q, COLUMN_BITS'(1));

		// pending data seen by the decision
		if (word_start) begin
			dec_pv  = (byte_pos_q != '0);
			dec_pos = start_pos;
			dec_pnl = prev_nl_q;
		end else begin
			dec_pv  = pend_valid_q;
			dec_pos = pend_pos_q;
			dec_pnl = pend_nl_q;
		end
		dec_wl = is_ws ? word_len_q : wl_inc;

		end_col   = col_add(column_q, dec_wl);
		nl        = end_col > COLUMN_BITS'(line_width_q);
		do_decide = (is_ws ? inside_word_q : last_s1) && dec_pv && (line_width_q != '0);

		// column after a whitespace byte: the word it ends, if any, plus the whitespace byte
		if (is_ws && inside_word_q) begin
			col_ws = col_add((do_decide && nl) ? word_len_q : end_col, COLUMN_BITS'(1));
		end else begin
			col_ws = col_add(column_q, COLUMN_BITS'(1));
		end

		pos_wide = WIDE_POS'(dec_pos);
	end

	// handshake: the stage moves unless a result is due and the output holds one not being taken
	assign out_free = !out_valid_q || out_ready;
	assign fire     = valid_s1 && (out_free || !do_decide);
	assign in_ready = !valid_s1 || fire;

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= '0;
		end else if (cfg_wr_en) begin
			line_width_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= text_byte;
			last_s1 <= para_last;
		end
	end

	// paragraph state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q      <= '0;
			byte_pos_q    <= '0;
			inside_word_q <= 1'b0;
			prev_nl_q     <= 1'b0;
			pend_valid_q  <= 1'b0;
			pend_pos_q    <= '0;
			pend_nl_q     <= 1'b0;
			word_len_q    <= '0;
		end else if (fire) begin
			if (last_s1) begin
				column_q      <= '0;
				byte_pos_q    <= '0;
				inside_word_q <= 1'b0;
				prev_nl_q     <= 1'b0;
				pend_valid_q  <= 1'b0;
				pend_pos_q    <= '0;
				pend_nl_q     <= 1'b0;
				word_len_q    <= '0;
			end else begin
				prev_nl_q <= (byte_s1 == CH_NEWLINE);
				if (byte_pos_q != POS_MAX) begin
					byte_pos_q <= byte_pos_q + POSITION_BITS'(1);
				end
				if (is_ws) begin
					column_q      <= col_ws;
					inside_word_q <= 1'b0;
					word_len_q    <= '0;
				end else begin
					inside_word_q <= 1'b1;
					word_len_q    <= wl_inc;
					if (word_start) begin
						pend_valid_q <= dec_pv;
						pend_pos_q   <= dec_pos;
						pend_nl_q    <= dec_pnl;
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && do_decide) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && do_decide) begin
			ws_position_q <= pos_wide[OUT_POS_BITS-1:0];
			becomes_nl_q  <= nl;
			was_changed_q <= (nl != dec_pnl);
		end
	end

	assign out_valid       = out_valid_q;
	assign ws_position     = ws_position_q;
	assign becomes_newline = becomes_nl_q;
	assign was_changed     = was_changed_q;

endmodule

// ===== tb/pgr_wrap_checker.sv =====
// Checker for the paragraph rewrap block: watches both channels, predicts decisions, compares.
`timescale 1ns / 100ps

module pgr_wrap_checker
	import pgr_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [WIDTH_BITS-1:0]   cfg_wr_data,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [BYTE_BITS-1:0]    text_byte,
	input  logic                    para_last,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic [OUT_POS_BITS-1:0] ws_position,
	input  logic                    becomes_newline,
	input  logic                    was_changed,
	output int                      fail_count,
	output int                      pending_count,
	output int                      bytes_checked,
	output int                      decisions_checked
);

	localparam int POS_W = POSITION_BITS_DEF;
	localparam int COL_W = COLUMN_BITS_DEF;

	typedef struct packed {
		logic [OUT_POS_BITS-1:0] pos;
		logic                    to_newline;
		logic                    changed;
	} wrap_decision_t;

	// Predicted decisions, oldest first
	wrap_decision_t wrap_q[$];

	// Shadow of the line width register and of the paragraph state
	logic [WIDTH_BITS-1:0] wrap_width;
	logic [COL_W-1:0]      cur_column;
	logic [COL_W-1:0]      word_len;
	logic [POS_W-1:0]      cur_offset;
	logic [POS_W-1:0]      gap_offset;
	logic                  word_open;
	logic                  prev_newline;
	logic                  gap_pending;
	logic                  gap_was_newline;

	int mismatches;
	int bytes_seen;
	int decisions_seen;

	function automatic logic [COL_W-1:0] col_sat_add(input logic [COL_W-1:0] a,
			input logic [COL_W-1:0] b);
		logic [COL_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[COL_W] ? {COL_W{1'b1}} : sum[COL_W-1:0];
	endfunction

	task automatic clear_paragraph();
		cur_column      = '0;
		word_len        = '0;
		cur_offset      = '0;
		gap_offset      = '0;
		word_open       = 1'b0;
		prev_newline    = 1'b0;
		gap_pending     = 1'b0;
		gap_was_newline = 1'b0;
	endtask

	// Word just ended: decide the whitespace in front of it, if there is one and the width is not zero
	task automatic close_word();
		logic [COL_W-1:0] end_col;
		wrap_decision_t   d;
		end_col = col_sat_add(cur_column, word_len);
		if (gap_pending && wrap_width != '0) begin
			d.to_newline = end_col > COL_W'(wrap_width);
			if (d.to_newline)
				cur_column = '0;
			d.pos     = gap_offset[OUT_POS_BITS-1:0];
			d.changed = d.to_newline != gap_was_newline;
			wrap_q.push_back(d);
		end
	endtask

	// Advance the shadow state by one accepted text byte
	task automatic track_byte(input logic [BYTE_BITS-1:0] b, input logic last);
		logic is_ws;
		is_ws = (b == CH_SPACE) || (b == CH_NEWLINE);
		if (!is_ws) begin
			if (!word_open) begin
				word_open   = 1'b1;
				word_len    = '0;
				gap_pending = cur_offset != '0;
				if (cur_offset == '0)
					gap_offset = '0;
				else if (cur_offset == '1)
					gap_offset = '1;
				else
					gap_offset = cur_offset - 1'b1;
				gap_was_newline = prev_newline;
			end
			word_len = col_sat_add(word_len, COL_W'(1));
			if (last)
				close_word();
		end else begin
			if (word_open) begin
				close_word();
				word_open  = 1'b0;
				cur_column = col_sat_add(cur_column, word_len);
				word_len   = '0;
			end
			cur_column = col_sat_add(cur_column, COL_W'(1));
		end
		prev_newline = b == CH_NEWLINE;
		if (cur_offset != '1)
			cur_offset = cur_offset + 1'b1;
		if (last)
			clear_paragraph();
	endtask

	always @(posedge clk or negedge arst_n) begin
		wrap_decision_t want;
		if (!arst_n) begin
			wrap_width = '0;
			clear_paragraph();
			wrap_q.delete();
			mismatches     = 0;
			bytes_seen     = 0;
			decisions_seen = 0;
		end else begin
			if (cfg_wr_en)
				wrap_width = cfg_wr_data;

			// Output beat: compare against the oldest prediction
			if (out_valid && out_ready) begin
				decisions_seen++;
				if (wrap_q.size() == 0) begin
					$error("decision beat with none expected: ws_position %0d", ws_position);
					mismatches++;
				end else begin
					want = wrap_q.pop_front();
					if (ws_position !== want.pos) begin
						$error("ws_position: expected %0d, got %0d", want.pos, ws_position);
						mismatches++;
					end
					if (becomes_newline !== want.to_newline) begin
						$error("becomes_newline: expected %0b, got %0b",
							want.to_newline, becomes_newline);
						mismatches++;
					end
					if (was_changed !== want.changed) begin
						$error("was_changed: expected %0b, got %0b", want.changed, was_changed);
						mismatches++;
					end
				end
			end

			// Input beat: predict
			if (in_valid && in_ready) begin
				bytes_seen++;
				track_byte(text_byte, para_last);
			end
		end
		fail_count        <= mismatches;
		pending_count     <= wrap_q.size();
		bytes_checked     <= bytes_seen;
		decisions_checked <= decisions_seen;
	end

endmodule

// ===== tb/paragraph_greedy_rewrap_tb.sv =====
// Testbench top for the paragraph rewrap block: stimulus, idling and verdict.
`timescale 1ns / 100ps

module paragraph_greedy_rewrap_tb
	import pgr_pkg::*;
;

	localparam int DRAIN_CYCLES    = 4;
	localparam int RANDOM_BYTES    = 1200;
	localparam int PHASE_BYTES     = 100;
	localparam int LONG_PARA_BYTES = 300;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [WIDTH_BITS-1:0]   cfg_wr_data;
	logic                    in_valid;
	logic                    in_ready;
	logic [BYTE_BITS-1:0]    text_byte;
	logic                    para_last;
	logic                    out_valid;
	logic                    out_ready;
	logic [OUT_POS_BITS-1:0] ws_position;
	logic                    becomes_newline;
	logic                    was_changed;

	int fail_count;
	int pending_count;
	int bytes_checked;
	int decisions_checked;

	// Paragraph being sent, and run bookkeeping
	logic [BYTE_BITS-1:0] para_buf[$];
	bit steady;
	int paragraphs_sent;
	int widths_written;
	int random_bytes;

	paragraph_greedy_rewrap uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.text_byte      (text_byte),
		.para_last      (para_last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.ws_position    (ws_position),
		.becomes_newline(becomes_newline),
		.was_changed    (was_changed)
	);

	pgr_wrap_checker chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.text_byte        (text_byte),
		.para_last        (para_last),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.ws_position      (ws_position),
		.becomes_newline  (becomes_newline),
		.was_changed      (was_changed),
		.fail_count       (fail_count),
		.pending_count    (pending_count),
		.bytes_checked    (bytes_checked),
		.decisions_checked(decisions_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit, far beyond the slowest correct run
	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [BYTE_BITS-1:0] pick_word_byte();
		logic [BYTE_BITS-1:0] b;
		b = CH_SPACE;
		while (b == CH_SPACE || b == CH_NEWLINE)
			b = BYTE_BITS'($urandom_range(0, 255));
		return b;
	endfunction

	function automatic logic [BYTE_BITS-1:0] pick_ws();
		return ($urandom_range(0, 1) == 1) ? CH_NEWLINE : CH_SPACE;
	endfunction

	// One input beat; valid is lowered only when a gap is drawn
	task automatic send_byte(input logic [BYTE_BITS-1:0] b, input logic last);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 10);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		text_byte <= b;
		para_last <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_para();
		int k;
		for (k = 0; k < para_buf.size(); k++)
			send_byte(para_buf[k], k == para_buf.size() - 1);
		paragraphs_sent++;
	endtask

	task automatic load_text(input string s);
		int k;
		for (k = 0; k < s.len(); k++)
			para_buf.push_back(s[k]);
	endtask

	// Stop sending and wait until every predicted decision has come out
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending_count == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_width(input logic [WIDTH_BITS-1:0] w);
		drain();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= w;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		widths_written++;
	endtask

	// Receiver: random stall before each result, none in steady stretches
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 10);
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		int i;
		int n;
		int w;
		int p;
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_wr_data     = '0;
		in_valid        = 1'b0;
		text_byte       = '0;
		para_last       = 1'b0;
		out_ready       = 1'b0;
		steady          = 1'b0;
		paragraphs_sent = 0;
		widths_written  = 0;
		random_bytes    = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Width left at its reset value of zero: state tracked, no decisions
		para_buf.delete();
		load_text("ab cd\nef");
		send_para();

		// Leading whitespace, extreme byte values, trailing whitespace
		set_width(WIDTH_BITS'(3));
		para_buf.delete();
		para_buf.push_back(CH_SPACE);
		para_buf.push_back(8'h00);
		para_buf.push_back(8'hFF);
		load_text(" xy\nz ");
		send_para();

		// Paragraph ending on a word byte, original newline kept or replaced
		para_buf.delete();
		load_text("ab\ncd e");
		send_para();

		// Long paragraph at full width, sent with no idling on either side
		set_width(8'hFF);
		steady = 1'b1;
		para_buf.delete();
		for (i = 0; i < LONG_PARA_BYTES; i++) begin
			if (i % 37 == 36)
				para_buf.push_back(pick_ws());
			else
				para_buf.push_back(pick_word_byte());
		end
		send_para();
		steady = 1'b0;

		// Random phases; each phase drains fully before its width write
		p = 0;
		while (random_bytes < RANDOM_BYTES) begin
			case (p)
				0: set_width(8'd1);
				1: set_width(8'hFF);
				2: set_width(8'd0);
				default: begin
					if ($urandom_range(0, 3) == 0)
						set_width(WIDTH_BITS'($urandom_range(0, 255)));
					else
						set_width(WIDTH_BITS'($urandom_range(2, 40)));
				end
			endcase
			steady = $urandom_range(0, 3) == 0;
			n = 0;
			while (n < PHASE_BYTES) begin
				para_buf.delete();
				if ($urandom_range(0, 9) == 0) begin
					// noise: arbitrary bytes, whitespace about a third of the time
					repeat ($urandom_range(1, 40)) begin
						if ($urandom_range(0, 2) == 0)
							para_buf.push_back(pick_ws());
						else
							para_buf.push_back(BYTE_BITS'($urandom_range(0, 255)));
					end
				end else begin
					if ($urandom_range(0, 4) == 0)
						repeat ($urandom_range(1, 3)) para_buf.push_back(pick_ws());
					for (w = $urandom_range(1, 10); w > 0; w--) begin
						if ($urandom_range(0, 7) == 0)
							repeat ($urandom_range(13, 60)) para_buf.push_back(pick_word_byte());
						else
							repeat ($urandom_range(1, 12)) para_buf.push_back(pick_word_byte());
						if (w > 1) begin
							para_buf.push_back(pick_ws());
							if ($urandom_range(0, 3) == 0)
								para_buf.push_back(pick_ws());
						end
					end
					if ($urandom_range(0, 4) == 0)
						para_buf.push_back(pick_ws());
				end
				send_para();
				n += para_buf.size();
			end
			random_bytes += n;
			p++;
		end
		steady = 1'b0;

		drain();
		$display("Run covered %0d bytes in %0d paragraphs under %0d line width writes,",
			bytes_checked, paragraphs_sent, widths_written);
		$display("with %0d wrap decisions compared, one paragraph of %0d bytes included.",
			decisions_checked, LONG_PARA_BYTES);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
